[src/tss_pkg.sv]
// Package for the task select scheduler: payload structs, command codes,
// sequencer states and table constants. No dependencies.
package tss_pkg;

  localparam int NUM_TASKS = 64;
  localparam int SLOT_W    = 6;

  localparam logic [31:0] SIG_ALARM_BIT   = 32'h0000_2000;
  localparam logic [31:0] SIG_UNBLOCKABLE = 32'h0004_0100;

  localparam logic [2:0] ST_RUNNING = 3'd0;
  localparam logic [2:0] ST_INTR    = 3'd1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SCHED = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  slot;
    logic        present;
    logic [2:0]  task_state;
    logic [7:0]  time_slice;
    logic [6:0]  prio;
    logic [30:0] alarm_time;
    logic [31:0] pending_signals;
    logic [31:0] blocked_signals;
    logic [30:0] now;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  next_task;
    logic        any_running;
    logic [7:0]  best_slice;
    logic        read_present;
    logic [2:0]  read_state;
    logic [7:0]  read_slice;
    logic [6:0]  read_prio;
    logic [30:0] read_alarm;
    logic [31:0] read_signals;
    logic [31:0] read_blocked;
  } out_item_t;

  typedef struct packed {
    logic        present;
    logic [2:0]  task_state;
    logic [7:0]  time_slice;
    logic [6:0]  prio;
    logic [30:0] alarm_time;
    logic [31:0] pending;
    logic [31:0] blocked;
  } slot_rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAKE_RD,
    S_WAKE_WR,
    S_PICK_RD,
    S_PICK_CMP,
    S_FILL_RD,
    S_FILL_WR,
    S_DONE
  } seq_state_t;

endpackage

[src/task_select_scheduler.sv]
// Task select scheduler top level: command decode and slot-walking sequencer.
// A write is done on acceptance; a read result beat follows the done state; a schedule
// runs a wake pass, a pick pass and, on a counter refill, a fill pass and a second pick pass.
// Reads and schedules hold busy from acceptance until the result strobe; one item at a time.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset clears the slot table and the sequencer.
module task_select_scheduler import tss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  seq_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [30:0]       now_r;
  logic [7:0]        best_r, best_nxt;
  logic [SLOT_W-1:0] win_r, win_nxt;
  logic              found_r, found_nxt;
  logic              pass2_r, pass2_nxt;
  logic              is_read_r;
  out_item_t         out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              refill_go;

  logic              we;
  logic [SLOT_W-1:0] waddr, raddr;
  slot_rec_t         wdata, rdata, woke;
  logic              sig_live;

  localparam logic [SLOT_W-1:0] TOP = SLOT_W'(NUM_TASKS - 1);

  tss_table u_table (
    .clk, .rst_n, .we, .waddr, .wdata, .raddr, .rdata
  );

  wire accept = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  always_comb begin
    woke = rdata;
    if (rdata.alarm_time != '0 && rdata.alarm_time < now_r) begin
      woke.pending    = rdata.pending | SIG_ALARM_BIT;
      woke.alarm_time = '0;
    end
    sig_live = (woke.pending & ~(rdata.blocked & ~SIG_UNBLOCKABLE)) != '0;
    if (sig_live && rdata.task_state == ST_INTR) begin
      woke.task_state = ST_RUNNING;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.cmd == CMD_SCHED) begin
            state_nxt = S_WAKE_RD;
          end else if (in_item.cmd == CMD_READ) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WAKE_RD:  state_nxt = S_WAKE_WR;
      S_WAKE_WR:  state_nxt = (idx_r == SLOT_W'(1)) ? S_PICK_RD : S_WAKE_RD;
      S_PICK_RD:  state_nxt = S_PICK_CMP;
      S_PICK_CMP: begin
        if (idx_r != SLOT_W'(1)) begin
          state_nxt = S_PICK_RD;
        end else if (refill_go) begin
          state_nxt = S_FILL_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FILL_RD:  state_nxt = S_FILL_WR;
      S_FILL_WR:  state_nxt = (idx_r == SLOT_W'(1)) ? S_PICK_RD : S_FILL_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt     = idx_r;
    best_nxt    = best_r;
    win_nxt     = win_r;
    found_nxt   = found_r;
    pass2_nxt   = pass2_r;
    out_nxt     = out_r;
    out_vld_nxt = 1'b0;
    refill_go   = 1'b0;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = woke;
    raddr       = idx_r;
    unique case (state_r)
      S_IDLE: begin
        raddr     = in_item.slot;
        idx_nxt   = TOP;
        best_nxt  = '0;
        win_nxt   = '0;
        found_nxt = 1'b0;
        pass2_nxt = 1'b0;
        if (accept && in_item.cmd == CMD_WRITE) begin
          we    = 1'b1;
          waddr = in_item.slot;
          wdata = '{present: in_item.present, task_state: in_item.task_state,
                    time_slice: in_item.time_slice, prio: in_item.prio,
                    alarm_time: in_item.alarm_time, pending: in_item.pending_signals,
                    blocked: in_item.blocked_signals};
        end
      end
      S_WAKE_WR: begin
        we      = rdata.present;
        idx_nxt = (idx_r == SLOT_W'(1)) ? TOP : idx_r - SLOT_W'(1);
      end
      S_PICK_CMP: begin
        if (rdata.present && rdata.task_state == ST_RUNNING &&
            (!found_r || rdata.time_slice > best_r)) begin
          best_nxt  = rdata.time_slice;
          win_nxt   = idx_r;
          found_nxt = 1'b1;
        end
        idx_nxt = (idx_r == SLOT_W'(1)) ? TOP : idx_r - SLOT_W'(1);
        if (idx_r == SLOT_W'(1)) begin
          raddr = '0;  // slot 0 counter for the no-runner case
          if (!pass2_r && found_nxt && best_nxt == '0) begin
            refill_go = 1'b1;
            pass2_nxt = 1'b1;
            best_nxt  = '0;
            win_nxt   = '0;
            found_nxt = 1'b0;
          end else begin
            idx_nxt = '0;
          end
        end
      end
      S_FILL_WR: begin
        we               = rdata.present;
        wdata            = rdata;
        wdata.time_slice = {1'b0, rdata.time_slice[7:1]} + {1'b0, rdata.prio};
        idx_nxt = (idx_r == SLOT_W'(1)) ? TOP : idx_r - SLOT_W'(1);
      end
      S_DONE: begin
        out_vld_nxt = 1'b1;
        out_nxt     = '0;
        if (is_read_r) begin
          out_nxt.read_present = rdata.present;
          out_nxt.read_state   = rdata.task_state;
          out_nxt.read_slice   = rdata.time_slice;
          out_nxt.read_prio    = rdata.prio;
          out_nxt.read_alarm   = rdata.alarm_time;
          out_nxt.read_signals = rdata.pending;
          out_nxt.read_blocked = rdata.blocked;
        end else begin
          out_nxt.next_task   = win_r;
          out_nxt.any_running = found_r;
          out_nxt.best_slice  = found_r ? best_r : rdata.time_slice;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    best_r  <= best_nxt;
    win_r   <= win_nxt;
    found_r <= found_nxt;
    pass2_r <= pass2_nxt;
    out_r   <= out_nxt;
    if (accept) begin
      now_r     <= in_item.now;
      is_read_r <= (in_item.cmd == CMD_READ);
    end
  end

endmodule

[src/tss_table.sv]
// Task table memory: one record per slot, one write and one registered read
// a cycle, valid bits cleared by reset. Depends on tss_pkg.
module tss_table import tss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  slot_rec_t         wdata,
  input  logic [SLOT_W-1:0] raddr,
  output slot_rec_t         rdata
);

  slot_rec_t             mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]  vld_r;
  logic                  rd_vld_r;
  slot_rec_t             rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  // never-written entries read as zero (reset value)
  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

[src/tss_checker.sv]
// Port-level checker for the task select scheduler, bound to the top level.
// Depends on tss_pkg.
module tss_checker import tss_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");

  a_idle_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy while result shown");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.read_present |-> out_item.next_task == '0 &&
    !out_item.any_running) else $error("read result carries schedule fields");

  a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.cmd == CMD_SCHED |=> busy)
    else $error("schedule beat did not raise busy");

endmodule

bind task_select_scheduler tss_checker u_tss_checker (.*);
